/* rtl/core/irdc_pkg.sv */
// ----------------------------------------------------------------------------
// irdc_pkg
// Shared types, constants and helpers of the IR distance calibration lookup:
// table geometry, item kinds, controller states, the default anchor curves.
// ----------------------------------------------------------------------------
package irdc_pkg;

  localparam int CURVE_LEN   = 136;
  localparam int TABLE_DEPTH = 2 * CURVE_LEN;
  localparam int ADDR_W      = 9;
  localparam int POS_W       = 8;
  localparam int SLOT_W      = 4;
  localparam int DIST_W      = 8;
  localparam int FIELD_W     = 16;
  localparam int ANCHOR_COUNT = 15;

  localparam logic [POS_W-1:0]  LAST_POS    = 8'd135;
  localparam logic [ADDR_W-1:0] RIGHT_BASE  = 9'd136;
  localparam logic [SLOT_W-1:0] LAST_SLOT   = 4'd14;
  localparam logic [SLOT_W-1:0] LAST_SPAN   = 4'd13;
  localparam logic [3:0]        PROBE_LAST  = 4'd15;
  localparam logic [3:0]        SHORT_SPAN  = 4'd5;
  localparam logic [3:0]        LONG_SPAN   = 4'd10;
  localparam logic [3:0]        DIV_BASE    = 4'd5;
  localparam logic [DIST_W-1:0] DIST_OFFSET = 8'd15;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_BUILD  = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WRITE,
    ST_LK_PROBE,
    ST_LK_CMP,
    ST_LK_LO,
    ST_LK_HI,
    ST_BD_RDA,
    ST_BD_RDB,
    ST_BD_DIFF,
    ST_BD_DIV,
    ST_BD_FILL,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
  } mem_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
    logic              is_distance;
  } result_t;

  localparam logic [FIELD_W-1:0] DEFAULT_LEFT [ANCHOR_COUNT] = '{
    16'd47279, 16'd43832, 16'd35163, 16'd27632, 16'd23340, 16'd21354, 16'd17369,
    16'd15520, 16'd13985, 16'd12598, 16'd11868, 16'd11100, 16'd10344, 16'd9645,
    16'd9187
  };

  localparam logic [FIELD_W-1:0] DEFAULT_RIGHT [ANCHOR_COUNT] = '{
    16'd47293, 16'd43218, 16'd34387, 16'd26817, 16'd22440, 16'd20391, 16'd16427,
    16'd14520, 16'd13386, 16'd12422, 16'd11220, 16'd10170, 16'd9860, 16'd9673,
    16'd8632
  };

  // Slot 0 sits at position 0, slot k at 10k-5.
  function automatic logic [POS_W-1:0] anchor_pos(input logic [SLOT_W-1:0] slot);
    logic [POS_W-1:0] s8;
    s8 = {4'b0000, slot};
    if (slot == '0) return '0;
    return (s8 << 3) + (s8 << 1) - 8'd5;
  endfunction

  function automatic logic [ADDR_W-1:0] table_addr(input logic sensor,
                                                   input logic [POS_W-1:0] pos);
    return {1'b0, pos} + (sensor ? RIGHT_BASE : '0);
  endfunction

  function automatic logic [FIELD_W-1:0] default_anchor(input logic sensor,
                                                        input logic [SLOT_W-1:0] slot);
    return sensor ? DEFAULT_RIGHT[slot] : DEFAULT_LEFT[slot];
  endfunction

endpackage

/* rtl/core/ir_distance_calibration_lookup.sv */
// ----------------------------------------------------------------------------
// ir_distance_calibration_lookup
// Two 136-entry calibration curves in one table store; anchor writes, linear
// build between anchors, and halving search from a reading to a distance.
// ----------------------------------------------------------------------------
// A write item passes ST_WRITE and then ST_RESULT, an unused item goes straight
//   to ST_RESULT; a lookup runs PROBE, CMP and then LO or HI per probe, at most 16 probes.
// Build item: 28 span passes, each through BD_RDA, BD_RDB, BD_DIFF and BD_DIV,
//   plus one table write per filled entry.
// One item at a time; the next item is taken while a result waits at m_*.
// Reset: 30 anchor writes plus a full build, with s_tready low.
module ir_distance_calibration_lookup #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // anchor_number[3:0], anchor_value[19:4], sample[35:20], zero
  input  logic [2:0]  s_tuser,  // op[1:0], sensor[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // distance[7:0]
  output logic [0:0]  m_tuser   // is_distance[0]
);

  irdc_pkg::mem_cmd_t        cmd;
  irdc_pkg::result_t         res;
  logic [SAMPLE_WIDTH-1:0]   wdata;
  logic [SAMPLE_WIDTH-1:0]   rd_data;
  logic                      div_start;
  logic [SAMPLE_WIDTH-1:0]   div_dividend;
  logic                      div_done;
  logic [SAMPLE_WIDTH-1:0]   div_quot;
  logic                      out_free;

  assign out_free = !m_tvalid || m_tready;

  irdc_ctrl #(.SW(SAMPLE_WIDTH)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (s_tvalid),
    .item_ready   (s_tready),
    .item_op      (s_tuser[1:0]),
    .item_sensor  (s_tuser[2]),
    .item_slot    (s_tdata[3:0]),
    .item_value   (s_tdata[19:4]),
    .item_sample  (s_tdata[35:20]),
    .rd_data      (rd_data),
    .cmd          (cmd),
    .wdata        (wdata),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .out_free     (out_free),
    .res          (res)
  );

  irdc_mem #(.SW(SAMPLE_WIDTH)) u_mem (
    .clk   (clk),
    .cmd   (cmd),
    .wdata (wdata),
    .rdata (rd_data)
  );

  irdc_div #(.SW(SAMPLE_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata    <= res.distance;
      m_tuser[0] <= res.is_distance;
    end
  end

  // an accepted item leaves s_tready low in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item taken while previous item still in progress");

  a_non_lookup_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
    else $error("non-lookup result carries a distance");

  a_distance_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata >= 8'd15) && (m_tdata <= 8'd150))
    else $error("lookup distance out of range");

endmodule

/* rtl/core/irdc_mem.sv */
// ----------------------------------------------------------------------------
// irdc_mem
// Calibration table store: both sensor curves, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module irdc_mem #(
  parameter int SW = 16
) (
  input  logic               clk,
  input  irdc_pkg::mem_cmd_t cmd,
  input  logic [SW-1:0]      wdata,
  output logic [SW-1:0]      rdata
);

  logic [SW-1:0] mem [irdc_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= wdata;
    end
    rdata <= mem[cmd.raddr];
  end

endmodule

/* rtl/core/irdc_div.sv */
// ----------------------------------------------------------------------------
// irdc_div
// Divider by five through reciprocal multiplication: the product is
// registered at start and the quotient is ready with done high next cycle.
// ----------------------------------------------------------------------------
module irdc_div #(
  parameter int SW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [SW-1:0] dividend,
  output logic          done,
  output logic [SW-1:0] quot
);

  // ceil(2^(SW+2) / 5) gives the exact floor quotient for every SW-bit dividend
  localparam logic [SW-1:0] RECIP =
    SW'(((64'd1 << (SW + 2)) / 64'(irdc_pkg::DIV_BASE)) + 64'd1);

  logic            busy;
  logic [2*SW-1:0] prod;

  assign done = busy;
  assign quot = {2'b00, prod[2*SW-1:SW+2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= {{SW{1'b0}}, dividend} * {{SW{1'b0}}, RECIP};
    end
  end

endmodule

/* rtl/core/irdc_ctrl.sv */
// ----------------------------------------------------------------------------
// irdc_ctrl
// Sequencer: anchor preload after reset, anchor writes, span-by-span table
// build, and the halving search of a lookup, all through the table store.
// ----------------------------------------------------------------------------
module irdc_ctrl #(
  parameter int SW = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [1:0]                   item_op,
  input  logic                         item_sensor,
  input  logic [irdc_pkg::SLOT_W-1:0]  item_slot,
  input  logic [irdc_pkg::FIELD_W-1:0] item_value,
  input  logic [irdc_pkg::FIELD_W-1:0] item_sample,
  input  logic [SW-1:0]                rd_data,
  output irdc_pkg::mem_cmd_t           cmd,
  output logic [SW-1:0]                wdata,
  output logic                         div_start,
  output logic [SW-1:0]                div_dividend,
  input  logic                         div_done,
  input  logic [SW-1:0]                div_quot,
  input  logic                         out_free,
  output irdc_pkg::result_t            res
);

  irdc_pkg::state_t state, state_next;

  logic                        accept;
  logic                        sensor_r;
  logic [irdc_pkg::SLOT_W-1:0] slot_r;
  logic [SW-1:0]               value_r;
  logic [SW-1:0]               sample_r;

  logic [irdc_pkg::POS_W-1:0]  lk_start, lk_start_next;
  logic [irdc_pkg::POS_W-1:0]  lk_end, lk_end_next;
  logic [irdc_pkg::POS_W-1:0]  lk_idx, lk_idx_next;
  logic [3:0]                  probe_cnt, probe_cnt_next;

  logic                        bd_sensor, bd_sensor_next;
  logic [irdc_pkg::SLOT_W-1:0] bd_span, bd_span_next;
  logic [3:0]                  bd_i, bd_i_next;
  logic [SW-1:0]               bd_a, bd_a_next;
  logic [SW-1:0]               bd_acc, bd_acc_next;
  logic [SW-1:0]               bd_step, bd_step_next;
  logic                        bd_neg, bd_neg_next;
  logic                        from_reset, from_reset_next;

  logic [irdc_pkg::DIST_W-1:0] dist_r, dist_next;
  logic                        isd_r, isd_next;

  logic [irdc_pkg::POS_W-1:0]  pos_a;
  logic [irdc_pkg::POS_W-1:0]  pos_b;
  logic [3:0]                  span_len;
  logic [irdc_pkg::POS_W:0]    lk_sum;
  logic [irdc_pkg::POS_W-1:0]  probe_idx;
  logic [SW:0]                 diff;
  logic [SW:0]                 mag_full;
  logic [SW-1:0]               mag;
  logic [SW-1:0]               step_val;

  assign accept    = item_valid && item_ready;
  assign pos_a     = irdc_pkg::anchor_pos(bd_span);
  assign pos_b     = irdc_pkg::anchor_pos(bd_span + 1'b1);
  assign span_len  = (bd_span == '0) ? irdc_pkg::SHORT_SPAN : irdc_pkg::LONG_SPAN;
  assign lk_sum    = {1'b0, lk_start} + {1'b0, lk_end};
  assign probe_idx = lk_sum[irdc_pkg::POS_W:1];
  assign diff      = {1'b0, rd_data} - {1'b0, bd_a};
  assign mag_full  = diff[SW] ? (~diff + 1'b1) : diff;
  assign mag       = mag_full[SW-1:0];
  assign step_val  = bd_neg ? (~div_quot + 1'b1) : div_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= irdc_pkg::ST_INIT;
      bd_sensor  <= 1'b0;
      bd_span    <= '0;
      from_reset <= 1'b1;
    end else begin
      state      <= state_next;
      bd_sensor  <= bd_sensor_next;
      bd_span    <= bd_span_next;
      from_reset <= from_reset_next;
      lk_start   <= lk_start_next;
      lk_end     <= lk_end_next;
      lk_idx     <= lk_idx_next;
      probe_cnt  <= probe_cnt_next;
      bd_i       <= bd_i_next;
      bd_a       <= bd_a_next;
      bd_acc     <= bd_acc_next;
      bd_step    <= bd_step_next;
      bd_neg     <= bd_neg_next;
      dist_r     <= dist_next;
      isd_r      <= isd_next;
      if (accept) begin
        sensor_r <= item_sensor;
        slot_r   <= item_slot;
        value_r  <= SW'(item_value);
        sample_r <= SW'(item_sample);
      end
    end
  end

  always_comb begin
    state_next      = state;
    lk_start_next   = lk_start;
    lk_end_next     = lk_end;
    lk_idx_next     = lk_idx;
    probe_cnt_next  = probe_cnt;
    bd_sensor_next  = bd_sensor;
    bd_span_next    = bd_span;
    bd_i_next       = bd_i;
    bd_a_next       = bd_a;
    bd_acc_next     = bd_acc;
    bd_step_next    = bd_step;
    bd_neg_next     = bd_neg;
    from_reset_next = from_reset;
    dist_next       = dist_r;
    isd_next        = isd_r;
    item_ready      = 1'b0;
    cmd             = '0;
    wdata           = '0;
    div_start       = 1'b0;
    div_dividend    = '0;
    res             = '0;

    unique case (state)
      irdc_pkg::ST_INIT: begin
        // preload the default anchors, then run a regular build
        cmd.we    = 1'b1;
        cmd.waddr = irdc_pkg::table_addr(bd_sensor, pos_a);
        wdata     = SW'(irdc_pkg::default_anchor(bd_sensor, bd_span));
        if (bd_span == irdc_pkg::LAST_SLOT) begin
          bd_span_next = '0;
          if (bd_sensor) begin
            bd_sensor_next = 1'b0;
            state_next     = irdc_pkg::ST_BD_RDA;
          end else begin
            bd_sensor_next = 1'b1;
          end
        end else begin
          bd_span_next = bd_span + 1'b1;
        end
      end

      irdc_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          dist_next = '0;
          isd_next  = 1'b0;
          unique case (item_op)
            irdc_pkg::OP_WRITE: begin
              state_next = irdc_pkg::ST_WRITE;
            end
            irdc_pkg::OP_BUILD: begin
              bd_sensor_next = 1'b0;
              bd_span_next   = '0;
              state_next     = irdc_pkg::ST_BD_RDA;
            end
            irdc_pkg::OP_LOOKUP: begin
              lk_start_next  = '0;
              lk_end_next    = irdc_pkg::LAST_POS;
              probe_cnt_next = '0;
              isd_next       = 1'b1;
              state_next     = irdc_pkg::ST_LK_PROBE;
            end
            default: begin
              state_next = irdc_pkg::ST_RESULT;
            end
          endcase
        end
      end

      irdc_pkg::ST_WRITE: begin
        // slots past the last anchor are dropped
        if (slot_r <= irdc_pkg::LAST_SLOT) begin
          cmd.we    = 1'b1;
          cmd.waddr = irdc_pkg::table_addr(sensor_r, irdc_pkg::anchor_pos(slot_r));
          wdata     = value_r;
        end
        state_next = irdc_pkg::ST_RESULT;
      end

      irdc_pkg::ST_LK_PROBE: begin
        if (probe_idx == '0 || probe_idx == irdc_pkg::LAST_POS || lk_start == lk_end) begin
          dist_next  = probe_idx + irdc_pkg::DIST_OFFSET;
          state_next = irdc_pkg::ST_RESULT;
        end else begin
          cmd.raddr   = irdc_pkg::table_addr(sensor_r, probe_idx);
          lk_idx_next = probe_idx;
          state_next  = irdc_pkg::ST_LK_CMP;
        end
      end

      irdc_pkg::ST_LK_CMP: begin
        if (rd_data < sample_r) begin
          cmd.raddr  = irdc_pkg::table_addr(sensor_r, lk_idx - 1'b1);
          state_next = irdc_pkg::ST_LK_LO;
        end else if (rd_data > sample_r) begin
          cmd.raddr  = irdc_pkg::table_addr(sensor_r, lk_idx + 1'b1);
          state_next = irdc_pkg::ST_LK_HI;
        end else begin
          dist_next  = lk_idx + irdc_pkg::DIST_OFFSET;
          state_next = irdc_pkg::ST_RESULT;
        end
      end

      irdc_pkg::ST_LK_LO: begin
        if (rd_data < sample_r) begin
          lk_end_next = lk_idx - 1'b1;
          if (probe_cnt == irdc_pkg::PROBE_LAST) begin
            dist_next  = lk_idx + irdc_pkg::DIST_OFFSET;
            state_next = irdc_pkg::ST_RESULT;
          end else begin
            probe_cnt_next = probe_cnt + 1'b1;
            state_next     = irdc_pkg::ST_LK_PROBE;
          end
        end else begin
          dist_next  = lk_idx + irdc_pkg::DIST_OFFSET - 1'b1;
          state_next = irdc_pkg::ST_RESULT;
        end
      end

      irdc_pkg::ST_LK_HI: begin
        if (rd_data > sample_r) begin
          lk_start_next = lk_idx + 1'b1;
          if (probe_cnt == irdc_pkg::PROBE_LAST) begin
            dist_next  = lk_idx + irdc_pkg::DIST_OFFSET;
            state_next = irdc_pkg::ST_RESULT;
          end else begin
            probe_cnt_next = probe_cnt + 1'b1;
            state_next     = irdc_pkg::ST_LK_PROBE;
          end
        end else begin
          dist_next  = lk_idx + irdc_pkg::DIST_OFFSET + 1'b1;
          state_next = irdc_pkg::ST_RESULT;
        end
      end

      irdc_pkg::ST_BD_RDA: begin
        cmd.raddr  = irdc_pkg::table_addr(bd_sensor, pos_a);
        state_next = irdc_pkg::ST_BD_RDB;
      end

      irdc_pkg::ST_BD_RDB: begin
        cmd.raddr  = irdc_pkg::table_addr(bd_sensor, pos_b);
        bd_a_next  = rd_data;
        state_next = irdc_pkg::ST_BD_DIFF;
      end

      irdc_pkg::ST_BD_DIFF: begin
        // divide the magnitude; a ten-wide span halves first (floor of floor)
        div_start    = 1'b1;
        div_dividend = (bd_span == '0) ? mag : (mag >> 1);
        bd_neg_next  = diff[SW];
        state_next   = irdc_pkg::ST_BD_DIV;
      end

      irdc_pkg::ST_BD_DIV: begin
        if (div_done) begin
          bd_step_next = step_val;
          bd_acc_next  = bd_a + step_val;
          bd_i_next    = 4'd1;
          state_next   = irdc_pkg::ST_BD_FILL;
        end
      end

      irdc_pkg::ST_BD_FILL: begin
        cmd.we      = 1'b1;
        cmd.waddr   = irdc_pkg::table_addr(bd_sensor, pos_a + {4'b0000, bd_i});
        wdata       = bd_acc;
        bd_acc_next = bd_acc + bd_step;
        bd_i_next   = bd_i + 1'b1;
        if (bd_i == span_len - 1'b1) begin
          if (bd_span == irdc_pkg::LAST_SPAN) begin
            bd_span_next = '0;
            if (bd_sensor) begin
              bd_sensor_next  = 1'b0;
              from_reset_next = 1'b0;
              state_next      = from_reset ? irdc_pkg::ST_IDLE : irdc_pkg::ST_RESULT;
            end else begin
              bd_sensor_next = 1'b1;
              state_next     = irdc_pkg::ST_BD_RDA;
            end
          end else begin
            bd_span_next = bd_span + 1'b1;
            state_next   = irdc_pkg::ST_BD_RDA;
          end
        end
      end

      irdc_pkg::ST_RESULT: begin
        // hold the result until the output register frees up
        if (out_free) begin
          res.valid       = 1'b1;
          res.distance    = dist_r;
          res.is_distance = isd_r;
          state_next      = irdc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = irdc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* sim/ir_distance_calibration_lookup_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_distance_calibration_lookup_test
// Drives anchor writes, curve builds, distance lookups and unused ops on both sensors,
// with random idle cycles on both buses. A scoreboard keeps its own copy of
// both calibration curves, predicts every reply and checks it field by field.
// ----------------------------------------------------------------------------
module ir_distance_calibration_lookup_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int POSITIONS    = 136;
  localparam int LAST_STEP    = 135;
  localparam int SLOTS        = 15;
  localparam int PROBE_CAP    = 16;
  localparam int STEP_OFFSET  = 15;
  localparam int STALL_PCT    = 12;
  localparam int RANDOM_ITEMS = 960;
  localparam int DRAIN_CYCLES = 64;
  localparam longint LIMIT_NS = 64'd16_000_000;

  typedef struct packed {
    logic [7:0] distance;
    logic       is_distance;
  } reply_t;

  localparam logic [15:0] LEFT_ANCHORS [SLOTS] = '{
    16'd47279, 16'd43832, 16'd35163, 16'd27632, 16'd23340, 16'd21354, 16'd17369,
    16'd15520, 16'd13985, 16'd12598, 16'd11868, 16'd11100, 16'd10344, 16'd9645,
    16'd9187
  };
  localparam logic [15:0] RIGHT_ANCHORS [SLOTS] = '{
    16'd47293, 16'd43218, 16'd34387, 16'd26817, 16'd22440, 16'd20391, 16'd16427,
    16'd14520, 16'd13386, 16'd12422, 16'd11220, 16'd10170, 16'd9860, 16'd9673,
    16'd8632
  };

  function automatic int slot_position(int slot);
    return (slot == 0) ? 0 : slot * 10 - 5;
  endfunction

  function automatic logic [15:0] default_anchor(logic sensor, int slot);
    return sensor ? RIGHT_ANCHORS[slot] : LEFT_ANCHORS[slot];
  endfunction

  class distance_checker;
    logic [15:0] curve [2][POSITIONS];
    reply_t expected_replies[$];
    int errors, lookups, writes, builds, ignored, replies;

    function new();
      for (int s = 0; s < 2; s++)
        for (int k = 0; k < SLOTS; k++)
          curve[s][slot_position(k)] = default_anchor(s[0], k);
      rebuild_curves();
    endfunction

    function void fill_span(int s, int pa, int span);
      int a, b, stride;
      a = curve[s][pa];
      b = curve[s][pa + span];
      stride = (b - a) / span;  // truncates toward zero
      for (int i = 1; i < span; i++)
        curve[s][pa + i] = 16'(a + stride * i);
    endfunction

    function void rebuild_curves();
      for (int s = 0; s < 2; s++) begin
        fill_span(s, 0, 5);
        for (int k = 1; k < SLOTS - 1; k++)
          fill_span(s, slot_position(k), 10);
      end
    endfunction

    function logic [7:0] predict_distance(logic sensor, logic [15:0] sample);
      int lo, hi, mid;
      lo = 0;
      hi = LAST_STEP;
      mid = 0;
      for (int probe = 0; probe < PROBE_CAP; probe++) begin
        mid = (lo + hi) / 2;
        if (mid <= 0 || mid >= LAST_STEP || lo == hi)
          return 8'((mid < 0 ? 0 : mid) + STEP_OFFSET);
        if (curve[sensor][mid] < sample) begin
          if (curve[sensor][mid - 1] < sample) hi = mid - 1;
          else return 8'(mid + STEP_OFFSET - 1);
        end else if (curve[sensor][mid] > sample) begin
          if (curve[sensor][mid + 1] > sample) lo = mid + 1;
          else return 8'(mid + STEP_OFFSET + 1);
        end else begin
          return 8'(mid + STEP_OFFSET);
        end
      end
      // search did not settle: take the last probe
      return 8'(mid + STEP_OFFSET);
    endfunction

    function logic [15:0] entry(logic sensor, int pos);
      return curve[sensor][pos];
    endfunction

    function void accept_item(logic [1:0] op, logic sensor, logic [3:0] slot,
                              logic [15:0] value, logic [15:0] sample);
      reply_t r;
      r = '0;
      case (op)
        irdc_pkg::OP_WRITE: begin
          writes++;
          if (slot < SLOTS) curve[sensor][slot_position(slot)] = value;
          else ignored++;
        end
        irdc_pkg::OP_BUILD: begin
          builds++;
          rebuild_curves();
        end
        irdc_pkg::OP_LOOKUP: begin
          lookups++;
          r.distance = predict_distance(sensor, sample);
          r.is_distance = 1'b1;
        end
        default: ignored++;
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [7:0] distance, logic is_distance);
      reply_t exp_r;
      replies++;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: reply with none expected: distance %0d is_distance %0d",
                 $time, distance, is_distance);
        return;
      end
      exp_r = expected_replies.pop_front();
      if (distance !== exp_r.distance) begin
        errors++;
        $display("%0t: distance mismatch: expected %0d, got %0d",
                 $time, exp_r.distance, distance);
      end
      if (is_distance !== exp_r.is_distance) begin
        errors++;
        $display("%0t: is_distance mismatch: expected %0d, got %0d",
                 $time, exp_r.is_distance, is_distance);
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // anchor_number[3:0], anchor_value[19:4], sample[35:20], zero
  logic [2:0]  s_tuser = '0;  // op[1:0], sensor[2]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // distance[7:0]
  logic [0:0]  m_tuser;       // is_distance[0]

  bit steady = 1'b0;
  distance_checker sb = new();

  ir_distance_calibration_lookup u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reply(m_tdata, m_tuser[0]);
  end

  initial begin
    #(LIMIT_NS);
    $display("ir_distance_calibration_lookup_test failed");
    $finish;
  end

  task automatic send_item(logic [1:0] op, logic sensor, logic [3:0] slot,
                           logic [15:0] value, logic [15:0] sample);
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, sample, value, slot};
    s_tuser  <= {sensor, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.accept_item(op, sensor, slot, value, sample);
  endtask

  task automatic lookup(logic sensor, logic [15:0] sample);
    send_item(irdc_pkg::OP_LOOKUP, sensor, 4'($urandom), 16'($urandom), sample);
  endtask

  task automatic write_anchor(logic sensor, logic [3:0] slot, logic [15:0] value);
    send_item(irdc_pkg::OP_WRITE, sensor, slot, value, 16'($urandom));
  endtask

  task automatic build_curves();
    send_item(irdc_pkg::OP_BUILD, 1'($urandom), 4'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] nudge(logic [15:0] base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  initial begin
    int done, r;
    logic sensor;
    logic [3:0] slot;
    logic [15:0] sample;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every op, ignored items, bent curves
    lookup(1'b0, 16'h0000);
    lookup(1'b0, 16'hFFFF);
    lookup(1'b1, 16'h0000);
    lookup(1'b1, 16'hFFFF);
    lookup(1'b0, 16'd21354);
    lookup(1'b1, 16'd8632);
    send_item(OP_UNUSED, 1'b1, 4'hF, 16'hFFFF, 16'hFFFF);
    write_anchor(1'b0, 4'd15, 16'hFFFF);
    write_anchor(1'b1, 4'd0, 16'hFFFF);
    write_anchor(1'b0, 4'd14, 16'h0000);
    build_curves();
    lookup(1'b0, 16'h0000);
    lookup(1'b1, 16'hFFFF);
    // raise a middle anchor above its neighbors on sensor 0, drop it to zero on sensor 1
    write_anchor(1'b0, 4'd7, 16'd60000);
    write_anchor(1'b1, 4'd7, 16'h0000);
    build_curves();
    lookup(1'b0, 16'd60000);
    lookup(1'b0, 16'd15520);
    lookup(1'b1, 16'd100);
    lookup(1'b1, 16'd30000);
    drain();

    done = 0;
    while (done < RANDOM_ITEMS) begin
      steady = (done >= 400 && done < 560);
      if (done == 700) drain();
      sensor = 1'($urandom);
      r = $urandom_range(99);
      if (r < 55) begin
        // mostly aim near a curve entry so the neighbor checks decide
        if ($urandom_range(9) < 6)
          sample = nudge(sb.entry(sensor, $urandom_range(LAST_STEP)), 3);
        else
          sample = 16'($urandom);
        lookup(sensor, sample);
        done++;
      end else if (r < 88) begin
        slot = ($urandom_range(15) == 0) ? 4'd15 : 4'($urandom_range(SLOTS - 1));
        if (slot == 4'd15)
          write_anchor(sensor, slot, 16'($urandom));
        else begin
          if ($urandom_range(3) != 0)
            write_anchor(sensor, slot, nudge(default_anchor(sensor, slot), 3000));
          else
            write_anchor(sensor, slot, 16'($urandom));
          done++;
        end
      end else if (r < 95) begin
        build_curves();
        done++;
      end else begin
        send_item(OP_UNUSED, sensor, 4'($urandom), 16'($urandom), 16'($urandom));
      end
    end
    steady = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d lookups, %0d anchor writes, %0d builds, %0d ignored items",
             sb.lookups, sb.writes, sb.builds, sb.ignored);
    $display("%0d replies checked, %0d mismatches", sb.replies, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("ir_distance_calibration_lookup_test passed");
    else
      $display("ir_distance_calibration_lookup_test failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/irdc_pkg.sv
rtl/core/irdc_mem.sv
rtl/core/irdc_div.sv
rtl/core/irdc_ctrl.sv
rtl/core/ir_distance_calibration_lookup.sv
sim/ir_distance_calibration_lookup_test.sv
